@@ rtl/core/sts_pkg.sv @@
// sts_pkg: shared types and constants for the sorted table search block.
// Holds item kinds, controller states and the cell link and control structs.
// No dependencies.
`default_nettype none

package sts_pkg;

	localparam int VALUE_W             = 32;
	localparam int POS_W               = 6;
	localparam int FILL_W              = 7;
	localparam int DEFAULT_TABLE_DEPTH = 64;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_SEARCH = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EVAL = 1'b1
	} state_t;

	// link from one cell to the next one up the chain
	typedef struct packed {
		logic                      ins;
		logic                      eq;
		logic signed [VALUE_W-1:0] entry;
	} cell_link_t;

	// per-cell control from the controller
	typedef struct packed {
		logic occupied;
		logic take;
	} cell_ctl_t;

endpackage : sts_pkg

`default_nettype wire

@@ rtl/core/sts_cell.sv @@
// sts_cell: one table entry with its compare logic and shift-insert mux.
// Depends on sts_pkg for the link and control structs.
`default_nettype none

module sts_cell (
	input  wire                              clk,
	input  wire sts_pkg::cell_ctl_t          ctl,
	input  wire signed [sts_pkg::VALUE_W-1:0] key,
	input  wire sts_pkg::cell_link_t         prev,
	output sts_pkg::cell_link_t              link,
	output logic                             first
);
	import sts_pkg::*;

	logic signed [VALUE_W-1:0] entry_q;

	// insertion point is at or below this cell once the entry is above the key
	always_comb begin
		link.entry = entry_q;
		link.ins   = !ctl.occupied || (entry_q > key);
		link.eq    = ctl.occupied && (entry_q == key);
		first      = link.eq && !prev.eq;
	end

	// shift the lower neighbor up, or drop the key in at the insertion point; hold below it
	always_ff @(posedge clk) begin
		if (ctl.take && link.ins) begin
			entry_q <= prev.ins ? prev.entry : key;
		end
	end

endmodule : sts_cell

`default_nettype wire

@@ rtl/core/sts_enc.sv @@
// sts_enc: one-hot to index encoder for the first matching cell.
// Depends on sts_pkg for the default depth.
`default_nettype none

module sts_enc #(
	parameter int DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire  [DEPTH-1:0]         hits,
	output logic [$clog2(DEPTH)-1:0] idx,
	output logic                     any
);
	import sts_pkg::*;

	localparam int IW = $clog2(DEPTH);

	always_comb begin
		idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (hits[i]) begin
				idx = idx | IW'(i);
			end
		end
		any = |hits;
	end

endmodule : sts_enc

`default_nettype wire

@@ rtl/core/sorted_table_search_top.sv @@
// sorted_table_search_top: sorted table held in a chain of cells with a small
// controller. An accepted word is registered, then evaluated by the cell chain
// into the result registers. The controller alternates an accept state and a
// cell-chain evaluation state; a pending result word stalls the evaluation.
// Reset: fill count cleared, table entries undefined until written.
// Depends on sts_pkg, sts_cell and sts_enc.
`default_nettype none

module sorted_table_search_top #(
	parameter int TABLE_DEPTH = sts_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [1:0]                        kind,
	input  wire  signed [sts_pkg::VALUE_W-1:0] value,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic                              found,
	output logic [sts_pkg::POS_W-1:0]         position,
	output logic                              overflow,
	output logic [sts_pkg::FILL_W-1:0]        fill_count
);
	import sts_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t                    state_q, state_d;
	kind_t                     kind_q;
	logic signed [VALUE_W-1:0] key_q;
	logic [CW-1:0]             count_q, count_d;
	logic                      out_valid_q;
	logic                      found_q, overflow_q;
	logic [POS_W-1:0]          position_q;
	logic [FILL_W-1:0]         fill_q;

	logic                      accept, advance, full, do_load;
	logic                      res_found, res_overflow;
	logic [TABLE_DEPTH-1:0]    hits;
	logic [IW-1:0]             hit_idx;
	logic                      hit_any;

	cell_link_t                links [TABLE_DEPTH];
	cell_ctl_t                 ctls  [TABLE_DEPTH];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EVAL;
			ST_EVAL: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		in_ready = 1'b0;
		advance  = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EVAL: advance  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign accept  = in_valid && in_ready;
	assign full    = (count_q == CW'(TABLE_DEPTH));
	assign do_load = advance && (kind_q == KIND_LOAD) && !full;

	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			cell_link_t prev_link;
			assign ctls[g].occupied = (CW'(g) < count_q);
			assign ctls[g].take     = do_load && (CW'(g) <= count_q);
			if (g == 0) begin : g_head
				assign prev_link = '0;
			end else begin : g_body
				assign prev_link = links[g-1];
			end
			sts_cell u_cell (
				.clk   (clk),
				.ctl   (ctls[g]),
				.key   (key_q),
				.prev  (prev_link),
				.link  (links[g]),
				.first (hits[g])
			);
		end
	endgenerate

	sts_enc #(.DEPTH(TABLE_DEPTH)) u_enc (
		.hits (hits),
		.idx  (hit_idx),
		.any  (hit_any)
	);

	// result and fill count for the word under evaluation
	always_comb begin
		count_d      = count_q;
		res_found    = 1'b0;
		res_overflow = 1'b0;
		unique case (kind_q)
			KIND_LOAD: begin
				if (full) res_overflow = 1'b1;
				else      count_d      = count_q + CW'(1);
			end
			KIND_SEARCH: res_found = hit_any;
			KIND_CLEAR:  count_d   = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (advance) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the accepted word and the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(kind);
			key_q  <= value;
		end
		if (advance) begin
			found_q    <= res_found;
			position_q <= res_found ? POS_W'(hit_idx) : '0;
			overflow_q <= res_overflow;
			fill_q     <= FILL_W'(count_d);
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign position   = position_q;
	assign overflow   = overflow_q;
	assign fill_count = fill_q;

endmodule : sorted_table_search_top

`default_nettype wire

@@ test/tb_sorted_table_search_top.sv @@
// tb_sorted_table_search_top: self-checking bench for the sorted table search block.
// A class keeps its own sorted table and predicts each result word, and tasks drive
// bursty loads and searches against a stalling receiver. Depends on sts_pkg and the RTL.
`timescale 1ns / 100ps

module tb_sorted_table_search_top;
	import sts_pkg::*;

	localparam int DEPTH = DEFAULT_TABLE_DEPTH;
	localparam int ITEMS = 900;
	localparam int LONG_HOLD = 150;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic                found;
		logic [POS_W-1:0]    position;
		logic                overflow;
		logic [FILL_W-1:0]   fill;
	} table_result_t;

	class table_scoreboard;
		logic signed [VALUE_W-1:0] entries [DEPTH];
		int unsigned held;
		table_result_t pending [$];
		int unsigned errors, checked, loads, drops, hits, misses, clears, unknowns;

		function new();
			held = 0;
			errors = 0;
			checked = 0;
			loads = 0;
			drops = 0;
			hits = 0;
			misses = 0;
			clears = 0;
			unknowns = 0;
		endfunction

		function void note_input(logic [1:0] k, logic signed [VALUE_W-1:0] v);
			table_result_t r;
			int at;
			r = '0;
			case (k)
			KIND_LOAD: begin
				if (held == DEPTH) begin
					r.overflow = 1'b1;
					drops++;
				end else begin
					// shift larger entries up; equal ones stay below the new value
					at = held;
					while (at > 0 && entries[at-1] > v) begin
						entries[at] = entries[at-1];
						at--;
					end
					entries[at] = v;
					held++;
					loads++;
				end
			end
			KIND_SEARCH: begin
				at = 0;
				while (at < held && entries[at] < v)
					at++;
				if (at < held && entries[at] == v) begin
					r.found = 1'b1;
					r.position = at[POS_W-1:0];
					hits++;
				end else begin
					misses++;
				end
			end
			KIND_CLEAR: begin
				held = 0;
				clears++;
			end
			default: begin
				unknowns++;
			end
			endcase
			r.fill = held[FILL_W-1:0];
			pending.push_back(r);
		endfunction

		function void compare_field(string name, logic [FILL_W-1:0] want, logic [FILL_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic f, logic [POS_W-1:0] p, logic o, logic [FILL_W-1:0] c);
			table_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word found=%0d position=%0d overflow=%0d fill=%0d",
					$time, f, p, o, c);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			compare_field("found", FILL_W'(want.found), FILL_W'(f));
			compare_field("position", FILL_W'(want.position), FILL_W'(p));
			compare_field("overflow", FILL_W'(want.overflow), FILL_W'(o));
			compare_field("fill_count", want.fill, c);
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [1:0]                 kind;
	logic signed [VALUE_W-1:0]  value;
	logic                       out_valid;
	logic                       out_ready;
	logic                       found;
	logic [POS_W-1:0]           position;
	logic                       overflow;
	logic [FILL_W-1:0]          fill_count;

	table_scoreboard sb = new();
	int unsigned sent = 0;
	int unsigned burst_left = 0;

	sorted_table_search_top #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.position(position),
		.overflow(overflow),
		.fill_count(fill_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_sorted_table_search_top NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(found, position, overflow, fill_count);
	end

	// offer one word, often idling between bursts, and hold it until accepted
	task automatic push_word(input logic [1:0] k, input logic signed [VALUE_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				kind <= 2'($urandom);
				value <= $urandom;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		value <= v;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(k, v);
		if (k != KIND_UNUSED)
			sent++;
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value(bit from_table);
		if (from_table && sb.held > 0 && $urandom_range(0, 3) != 0)
			return sb.entries[$urandom_range(0, sb.held - 1)];
		case ($urandom_range(0, 9))
		0, 1: return int'($urandom_range(0, 8)) - 4;
		2: begin
			case ($urandom_range(0, 3))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'sh0;
			default: return -32'sd1;
			endcase
		end
		3: begin
			if (sb.held > 0)
				return sb.entries[$urandom_range(0, sb.held - 1)] + int'($urandom_range(0, 2)) - 1;
			return $urandom;
		end
		default: return $urandom;
		endcase
	endfunction

	// receiver: stall patterns of random span, plus one long hold-off to back up the input
	initial begin : rx_pattern
		int mode;
		int span;
		bit held_off;
		held_off = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held_off && sb.checked >= 40) begin
				held_off = 1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			mode = $urandom_range(0, 4);
			span = $urandom_range(4, 60);
			repeat (span) begin
				case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ~out_ready;
				2: out_ready <= ($urandom_range(0, 1) == 1);
				3: out_ready <= ($urandom_range(0, 7) == 0);
				default: out_ready <= ($urandom_range(0, 31) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int ep;
		int steps;
		int load_pct;
		int r;
		in_valid <= 1'b0;
		kind <= KIND_LOAD;
		value <= '0;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_word(KIND_SEARCH, 32'sh0);
		push_word(KIND_UNUSED, 32'shffff_ffff);
		push_word(KIND_LOAD, 32'sh0);
		push_word(KIND_LOAD, 32'sh7fff_ffff);
		push_word(KIND_LOAD, 32'sh8000_0000);
		push_word(KIND_LOAD, -32'sd1);
		push_word(KIND_LOAD, 32'sd5);
		push_word(KIND_LOAD, 32'sd5);
		push_word(KIND_LOAD, 32'sd5);
		push_word(KIND_SEARCH, 32'sd5);
		push_word(KIND_SEARCH, 32'sh8000_0000);
		push_word(KIND_SEARCH, 32'sh7fff_ffff);
		push_word(KIND_SEARCH, 32'sd4);
		push_word(KIND_SEARCH, -32'sd2);
		push_word(KIND_UNUSED, 32'sh5555_5555);
		push_word(KIND_LOAD, 32'sd1);
		push_word(KIND_SEARCH, 32'sd1);
		push_word(KIND_SEARCH, -32'sd1);
		push_word(KIND_CLEAR, 32'shaaaa_aaaa);
		push_word(KIND_SEARCH, 32'sd5);
		push_word(KIND_LOAD, -32'sd7);
		push_word(KIND_SEARCH, -32'sd7);
		push_word(KIND_CLEAR, 32'sh0);

		// episodes of loads and searches, each closed by a clear; the first fills the table
		ep = 0;
		while (sent < ITEMS) begin
			if (ep == 0 || $urandom_range(0, 3) == 0) begin
				steps = $urandom_range(90, 140);
				load_pct = 80;
			end else begin
				steps = $urandom_range(5, 40);
				load_pct = 50;
			end
			if (ep == 0)
				steps = 110;
			repeat (steps) begin
				r = $urandom_range(0, 99);
				if (r < load_pct)
					push_word(KIND_LOAD, pick_value(0));
				else if (r < 95)
					push_word(KIND_SEARCH, pick_value(1));
				else if (r < 98)
					push_word(KIND_UNUSED, $urandom);
				else
					push_word(KIND_CLEAR, $urandom);
			end
			push_word(KIND_CLEAR, $urandom);
			ep++;
		end

		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("words checked %0d: %0d loads, %0d dropped on a full table, %0d clears, %0d unused kind",
			sb.checked, sb.loads, sb.drops, sb.clears, sb.unknowns);
		$display("searches: %0d hits, %0d misses, over %0d table episodes", sb.hits, sb.misses, ep);
		if (sb.errors == 0)
			$display("tb_sorted_table_search_top OK");
		else
			$display("tb_sorted_table_search_top NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/sts_pkg.sv
rtl/core/sts_cell.sv
rtl/core/sts_enc.sv
rtl/core/sorted_table_search_top.sv
test/tb_sorted_table_search_top.sv
